// ===== rtl/core/hds_pkg.sv =====
// shared types, constants and helpers for the heat diffusion stencil step
// no dependencies; every other file except hds_ram refers to this package by scoped names
`timescale 1ns / 1ps

package hds_pkg;

   // fixed field widths
   localparam int VALUE_W    = 32;          // q16.16 temperature
   localparam int FRAC_W     = 16;          // fractional bits of value and coefficient
   localparam int CNT_W      = 10;          // row and column index
   localparam int CFG_DIM_W  = 11;          // grid size register
   localparam int COEF_W     = 15;          // diffusion coefficient register
   localparam int CSR_IDX_W  = 2;

   // grid limits
   localparam int MAX_WIDTH  = 1024;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int GRID_MIN   = 3;
   localparam int GRID_W_MAX = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int GRID_H_MAX = 1024;

   // datapath widths
   localparam int SUM_W  = VALUE_W + 3;              // exact five point sum
   localparam int PROD_W = SUM_W + COEF_W + 1;       // sum times zero-extended coeff
   localparam int SAT_W  = SUM_W + 1;                // widest value before saturation
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2 ** (FRAC_W - 1));

   // reset values of the registers
   localparam logic [CFG_DIM_W-1:0]      RST_GRID_WIDTH  = CFG_DIM_W'(16);
   localparam logic [CFG_DIM_W-1:0]      RST_GRID_HEIGHT = CFG_DIM_W'(16);
   localparam logic [COEF_W-1:0]         RST_COEFF       = COEF_W'(9830);
   localparam logic signed [VALUE_W-1:0] RST_BOTTOM      = VALUE_W'(3276800);

   // result queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_COEFF       = 2'd2,
      CSR_BOTTOM      = 2'd3
   } csr_index_type;

   // which results a cell produces, in emission order
   localparam int EMIT_W        = 4;
   localparam int EMIT_INT      = 0;   // interior cell above-left
   localparam int EMIT_INT_BOT  = 1;   // row zero copy of that interior cell
   localparam int EMIT_SELF     = 2;   // side column or last row, passed through
   localparam int EMIT_SELF_BOT = 3;   // row zero copy of a row one side cell

   typedef struct packed {
      logic [CFG_DIM_W-1:0]      grid_width;
      logic [CFG_DIM_W-1:0]      grid_height;
      logic [COEF_W-1:0]         diffusion_coeff;
      logic signed [VALUE_W-1:0] bottom_offset;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]          row;
      logic [CNT_W-1:0]          col;
      logic signed [VALUE_W-1:0] nv;
      logic signed [VALUE_W-1:0] nv_bot;
      logic signed [VALUE_W-1:0] x;
      logic signed [VALUE_W-1:0] x_bot;
      logic [EMIT_W-1:0]         emit;
   } entry_type;

   // clip a wide signed value to the signed value range
   function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [SAT_W-1:0] v);
      logic in_range;
      in_range = (&v[SAT_W-1:VALUE_W-1]) || (~|v[SAT_W-1:VALUE_W-1]);
      if (in_range) begin
         return v[VALUE_W-1:0];
      end else if (v[SAT_W-1]) begin
         return {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(VALUE_W-1){1'b1}}};
      end
   endfunction

endpackage

// ===== rtl/core/heat_diffusion_stencil_step.sv =====
// top level of the heat diffusion stencil step: register file, front, queue, back
// depends on hds_pkg, hds_front, hds_queue, hds_back
`timescale 1ns / 1ps

// One explicit time step of the 2D heat equation (five point stencil) over a grid
// of grid_width x grid_height q16.16 cells that arrive in raster order, row 0 and
// column 0 first. An interior cell becomes a + k*(left + right + up + down - 4a),
// rounded half up and saturated; side columns and the last row pass through; each
// row 0 cell is bottom_offset plus the new row 1 cell of its column. Each result
// carries its row and column and leaves in the order the stencil completes them,
// with last set on the final result that a cell causes (rows 0 and the interior of
// row 1 cause none). The block takes one cell per clock while req_ready is high;
// results leave at one per clock from the output register while rsp_ready is
// high, so cells that cause results beyond their first hold off req_ready only
// after the four-entry queue between front and back has filled. On
// its way out a cell's first result passes the line store read at the transfer
// edge, the sum, multiply and round registers, the queue and the output register.
// The line stores are two 1024 x 32 rams with no clearing pass; no result ever
// depends on an entry not yet written in the current grid. Writing grid_width or
// grid_height restarts the raster at row 0, column 0; the user must write registers
// only while the block is idle, which the block itself does not enforce.
module heat_diffusion_stencil_step (
   input  logic                               clock,
   input  logic                               reset,
   // input cells
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [hds_pkg::VALUE_W-1:0] req_cell_value,
   // results
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hds_pkg::CNT_W-1:0]          rsp_out_row,
   output logic [hds_pkg::CNT_W-1:0]          rsp_out_col,
   output logic signed [hds_pkg::VALUE_W-1:0] rsp_new_value,
   output logic                               rsp_last,
   // register writes
   input  logic                               csr_wr_en,
   input  logic [hds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hds_pkg::VALUE_W-1:0]        csr_wr_data
);

   hds_pkg::cfg_type   cfg_ff, cfg_in;
   logic               restart;

   logic               push, pop, queue_full, queue_not_empty;
   hds_pkg::entry_type push_entry, head;

   // register file; a size write also restarts the raster
   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (csr_wr_en) begin
         unique case (hds_pkg::csr_index_type'(csr_index))
            hds_pkg::CSR_GRID_WIDTH: begin
               cfg_in.grid_width = csr_wr_data[hds_pkg::CFG_DIM_W-1:0];
               restart           = 1'b1;
            end
            hds_pkg::CSR_GRID_HEIGHT: begin
               cfg_in.grid_height = csr_wr_data[hds_pkg::CFG_DIM_W-1:0];
               restart            = 1'b1;
            end
            hds_pkg::CSR_COEFF: begin
               cfg_in.diffusion_coeff = csr_wr_data[hds_pkg::COEF_W-1:0];
            end
            hds_pkg::CSR_BOTTOM: begin
               cfg_in.bottom_offset = csr_wr_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width      <= hds_pkg::RST_GRID_WIDTH;
         cfg_ff.grid_height     <= hds_pkg::RST_GRID_HEIGHT;
         cfg_ff.diffusion_coeff <= hds_pkg::RST_COEFF;
         cfg_ff.bottom_offset   <= hds_pkg::RST_BOTTOM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: counters, classification, line stores and stencil arithmetic
   hds_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .restart       (restart),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cell_value(req_cell_value),
      .push          (push),
      .push_entry    (push_entry),
      .queue_full    (queue_full)
   );

   // only cells that cause a result enter the queue
   hds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // back: one result transfer per cycle while results wait and rsp_ready is high
   hds_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (queue_not_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_new_value(rsp_new_value),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== rtl/core/hds_ram.sv =====
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module hds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hds_front.sv =====
// front part: raster counters, result classification, line stores, stencil pipeline
// depends on hds_pkg and hds_ram
`timescale 1ns / 1ps

module hds_front (
   input  logic                          clock,
   input  logic                          reset,
   input  hds_pkg::cfg_type              cfg,
   input  logic                          restart,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [hds_pkg::VALUE_W-1:0] req_cell_value,
   output logic                          push,
   output hds_pkg::entry_type            push_entry,
   input  logic                          queue_full
);

   // grid position of the next cell
   logic [hds_pkg::CNT_W-1:0] row_ff, row_in;
   logic [hds_pkg::CNT_W-1:0] col_ff, col_in;

   logic [hds_pkg::CFG_DIM_W-1:0] w_eff, h_eff;
   logic [hds_pkg::CNT_W-1:0]     col_last, row_last;

   logic                          adv, acc;
   logic [hds_pkg::EMIT_W-1:0]    emit_now;
   logic                          side_col;

   // stage 1: line store data arrives
   logic                                s1_valid_ff;
   logic signed [hds_pkg::VALUE_W-1:0]  s1_x_ff;
   logic [hds_pkg::CNT_W-1:0]           s1_row_ff, s1_col_ff;
   logic [hds_pkg::EMIT_W-1:0]          s1_emit_ff;
   logic signed [hds_pkg::VALUE_W-1:0]  mid_rd, up_rd;
   logic signed [hds_pkg::SUM_W-1:0]    s1_sum;

   // window: left, centre, up; and the cell below the centre
   logic signed [hds_pkg::VALUE_W-1:0]  win_left_ff, win_centre_ff, win_up_ff, held_below_ff;

   // stage 2: multiply
   logic                                s2_valid_ff;
   logic signed [hds_pkg::SUM_W-1:0]    s2_sum_ff;
   logic signed [hds_pkg::VALUE_W-1:0]  s2_a_ff, s2_x_ff;
   logic [hds_pkg::CNT_W-1:0]           s2_row_ff, s2_col_ff;
   logic [hds_pkg::EMIT_W-1:0]          s2_emit_ff;
   logic signed [hds_pkg::COEF_W:0]     coeff_s;
   logic signed [hds_pkg::PROD_W-1:0]   s2_prod;

   // stage 3: round and add
   logic                                s3_valid_ff;
   logic signed [hds_pkg::PROD_W-1:0]   s3_prod_ff;
   logic signed [hds_pkg::VALUE_W-1:0]  s3_a_ff, s3_x_ff;
   logic [hds_pkg::CNT_W-1:0]           s3_row_ff, s3_col_ff;
   logic [hds_pkg::EMIT_W-1:0]          s3_emit_ff;
   logic signed [hds_pkg::PROD_W-1:0]   s3_rounded;
   logic signed [hds_pkg::SUM_W-1:0]    s3_inc;
   logic signed [hds_pkg::VALUE_W-1:0]  s3_nv;

   // stage 4: row zero offsets, then into the queue
   logic                                s4_valid_ff;
   logic signed [hds_pkg::VALUE_W-1:0]  s4_nv_ff, s4_x_ff;
   logic [hds_pkg::CNT_W-1:0]           s4_row_ff, s4_col_ff;
   logic [hds_pkg::EMIT_W-1:0]          s4_emit_ff;

   // effective grid size
   always_comb begin
      w_eff = cfg.grid_width;
      if (w_eff < hds_pkg::CFG_DIM_W'(hds_pkg::GRID_MIN)) begin
         w_eff = hds_pkg::CFG_DIM_W'(hds_pkg::GRID_MIN);
      end else if (w_eff > hds_pkg::CFG_DIM_W'(hds_pkg::GRID_W_MAX)) begin
         w_eff = hds_pkg::CFG_DIM_W'(hds_pkg::GRID_W_MAX);
      end
      h_eff = cfg.grid_height;
      if (h_eff < hds_pkg::CFG_DIM_W'(hds_pkg::GRID_MIN)) begin
         h_eff = hds_pkg::CFG_DIM_W'(hds_pkg::GRID_MIN);
      end else if (h_eff > hds_pkg::CFG_DIM_W'(hds_pkg::GRID_H_MAX)) begin
         h_eff = hds_pkg::CFG_DIM_W'(hds_pkg::GRID_H_MAX);
      end
   end

   assign col_last = hds_pkg::CNT_W'(w_eff - 1'b1);
   assign row_last = hds_pkg::CNT_W'(h_eff - 1'b1);

   // whole pipeline moves together; it stops only when the queue cannot take a push
   assign adv       = !(s4_valid_ff && (|s4_emit_ff) && queue_full);
   assign req_ready = adv;
   assign acc       = req_valid && adv;

   // classify the arriving cell
   always_comb begin
      side_col = (col_ff == '0) || (col_ff == col_last);
      emit_now = '0;
      emit_now[hds_pkg::EMIT_INT]      = (row_ff >= hds_pkg::CNT_W'(2)) &&
                                         (col_ff >= hds_pkg::CNT_W'(2));
      emit_now[hds_pkg::EMIT_INT_BOT]  = emit_now[hds_pkg::EMIT_INT] &&
                                         (row_ff == hds_pkg::CNT_W'(2));
      emit_now[hds_pkg::EMIT_SELF]     = (row_ff != '0) && (side_col || (row_ff == row_last));
      emit_now[hds_pkg::EMIT_SELF_BOT] = (row_ff == hds_pkg::CNT_W'(1)) && side_col;
   end

   // raster counters
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (acc) begin
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // line stores: read at accept, written back from stage 1
   hds_ram #(
      .WIDTH(hds_pkg::VALUE_W),
      .DEPTH(hds_pkg::MAX_WIDTH)
   ) u_store_upper (
      .clock  (clock),
      .wr_en  (adv && s1_valid_ff),
      .wr_addr(s1_col_ff[hds_pkg::ADDR_W-1:0]),
      .wr_data(mid_rd),
      .rd_en  (acc),
      .rd_addr(col_ff[hds_pkg::ADDR_W-1:0]),
      .rd_data(up_rd)
   );

   hds_ram #(
      .WIDTH(hds_pkg::VALUE_W),
      .DEPTH(hds_pkg::MAX_WIDTH)
   ) u_store_middle (
      .clock  (clock),
      .wr_en  (adv && s1_valid_ff),
      .wr_addr(s1_col_ff[hds_pkg::ADDR_W-1:0]),
      .wr_data(s1_x_ff),
      .rd_en  (acc),
      .rd_addr(col_ff[hds_pkg::ADDR_W-1:0]),
      .rd_data(mid_rd)
   );

   // stage 1: exact stencil sum, left + right + up + down - 4 * centre
   assign s1_sum = hds_pkg::SUM_W'(win_left_ff) + hds_pkg::SUM_W'(mid_rd) +
                   hds_pkg::SUM_W'(win_up_ff) + hds_pkg::SUM_W'(held_below_ff) -
                   (hds_pkg::SUM_W'(win_centre_ff) <<< 2);

   // stage 2: scale by the coefficient
   assign coeff_s = {1'b0, cfg.diffusion_coeff};
   assign s2_prod = s2_sum_ff * coeff_s;

   // stage 3: round half up, add to the old centre, saturate
   assign s3_rounded = s3_prod_ff + hds_pkg::ROUND_HALF;
   assign s3_inc     = s3_rounded[hds_pkg::PROD_W-1:hds_pkg::FRAC_W];
   assign s3_nv      = hds_pkg::sat_value(hds_pkg::SAT_W'(s3_a_ff) + hds_pkg::SAT_W'(s3_inc));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         win_left_ff   <= '0;
         win_centre_ff <= '0;
         win_up_ff     <= '0;
         held_below_ff <= '0;
      end else if (adv) begin
         s1_valid_ff <= acc;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         if (s1_valid_ff) begin
            win_left_ff   <= win_centre_ff;
            win_centre_ff <= mid_rd;
            win_up_ff     <= up_rd;
            held_below_ff <= s1_x_ff;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff    <= req_cell_value;
         s1_row_ff  <= row_ff;
         s1_col_ff  <= col_ff;
         s1_emit_ff <= emit_now;

         s2_sum_ff  <= s1_sum;
         s2_a_ff    <= win_centre_ff;
         s2_x_ff    <= s1_x_ff;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_emit_ff <= s1_emit_ff;

         s3_prod_ff <= s2_prod;
         s3_a_ff    <= s2_a_ff;
         s3_x_ff    <= s2_x_ff;
         s3_row_ff  <= s2_row_ff;
         s3_col_ff  <= s2_col_ff;
         s3_emit_ff <= s2_emit_ff;

         s4_nv_ff   <= s3_nv;
         s4_x_ff    <= s3_x_ff;
         s4_row_ff  <= s3_row_ff;
         s4_col_ff  <= s3_col_ff;
         s4_emit_ff <= s3_emit_ff;
      end
   end

   // stage 4: row zero values, entry to the queue
   assign push = adv && s4_valid_ff && (|s4_emit_ff);

   always_comb begin
      push_entry.row    = s4_row_ff;
      push_entry.col    = s4_col_ff;
      push_entry.nv     = s4_nv_ff;
      push_entry.nv_bot = hds_pkg::sat_value(hds_pkg::SAT_W'(cfg.bottom_offset) +
                                             hds_pkg::SAT_W'(s4_nv_ff));
      push_entry.x      = s4_x_ff;
      push_entry.x_bot  = hds_pkg::sat_value(hds_pkg::SAT_W'(cfg.bottom_offset) +
                                             hds_pkg::SAT_W'(s4_x_ff));
      push_entry.emit   = s4_emit_ff;
   end

endmodule

// ===== rtl/core/hds_queue.sv =====
// short fifo of classified cells between the front and the back
// depends on hds_pkg
`timescale 1ns / 1ps

module hds_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hds_pkg::entry_type push_entry,
   input  logic               pop,
   output hds_pkg::entry_type head,
   output logic               not_empty,
   output logic               full
);

   hds_pkg::entry_type slot_ff [hds_pkg::QUEUE_DEPTH];
   logic [hds_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [hds_pkg::QCNT_W-1:0] count_ff, count_in;

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == hds_pkg::QCNT_W'(hds_pkg::QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/hds_back.sv =====
// back part: queued cells become results in the output register, one per cycle unless stalled
// depends on hds_pkg
`timescale 1ns / 1ps

module hds_back (
   input  logic                               clock,
   input  logic                               reset,
   input  hds_pkg::entry_type                 head,
   input  logic                               head_valid,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hds_pkg::CNT_W-1:0]          rsp_out_row,
   output logic [hds_pkg::CNT_W-1:0]          rsp_out_col,
   output logic signed [hds_pkg::VALUE_W-1:0] rsp_new_value,
   output logic                               rsp_last
);

   // cell being expanded and the results it still owes
   hds_pkg::entry_type         cur_ff;
   logic [hds_pkg::EMIT_W-1:0] cur_pend_ff, cur_pend_in;

   hds_pkg::entry_type         src;
   logic [hds_pkg::EMIT_W-1:0] src_pend;
   logic                       src_avail, load;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [hds_pkg::CNT_W-1:0]          row_ff, row_in;
   logic [hds_pkg::CNT_W-1:0]          col_ff, col_in;
   logic signed [hds_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                               last_ff, last_in;

   always_comb begin
      if (cur_pend_ff != '0) begin
         src      = cur_ff;
         src_pend = cur_pend_ff;
      end else begin
         src      = head;
         src_pend = head.emit;
      end
      src_avail = (cur_pend_ff != '0) || head_valid;
      load      = src_avail && (!rsp_valid_ff || rsp_ready);
      pop       = load && (cur_pend_ff == '0);

      // first owed result in emission order
      cur_pend_in = src_pend;
      row_in      = src.row;
      col_in      = src.col;
      value_in    = src.x;
      if (src_pend[hds_pkg::EMIT_INT]) begin
         row_in   = src.row - 1'b1;
         col_in   = src.col - 1'b1;
         value_in = src.nv;
         cur_pend_in[hds_pkg::EMIT_INT] = 1'b0;
      end else if (src_pend[hds_pkg::EMIT_INT_BOT]) begin
         row_in   = '0;
         col_in   = src.col - 1'b1;
         value_in = src.nv_bot;
         cur_pend_in[hds_pkg::EMIT_INT_BOT] = 1'b0;
      end else if (src_pend[hds_pkg::EMIT_SELF]) begin
         cur_pend_in[hds_pkg::EMIT_SELF] = 1'b0;
      end else begin
         row_in   = '0;
         value_in = src.x_bot;
         cur_pend_in[hds_pkg::EMIT_SELF_BOT] = 1'b0;
      end
      last_in = (cur_pend_in == '0);

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_pend_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            cur_pend_ff <= cur_pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff   <= src;
         row_ff   <= row_in;
         col_ff   <= col_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_new_value = value_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== rtl/core/hds_checker.sv =====
// port level checks for heat_diffusion_stencil_step, attached by bind
// depends on hds_pkg
`timescale 1ns / 1ps

module hds_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [hds_pkg::CNT_W-1:0]          rsp_out_row,
   input logic [hds_pkg::CNT_W-1:0]          rsp_out_col,
   input logic signed [hds_pkg::VALUE_W-1:0] rsp_new_value,
   input logic                               rsp_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_row) &&
         $stable(rsp_out_col) && $stable(rsp_new_value) && $stable(rsp_last))
      else $error("stalled result changed");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // the input side only stalls behind a waiting result
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // the results of one cell leave back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside the results of one cell");

endmodule

bind heat_diffusion_stencil_step hds_checker u_hds_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_row  (rsp_out_row),
   .rsp_out_col  (rsp_out_col),
   .rsp_new_value(rsp_new_value),
   .rsp_last     (rsp_last)
);
